### hw/rtl/window_median_filter_top_macros.svh
// Assertion helpers used by the median back end of the filter.
`ifndef WINDOW_MEDIAN_FILTER_TOP_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_TOP_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define WMF_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define WMF_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/wmf_pkg.sv
package wmf_pkg;

   localparam int WindowW  = 3;
   localparam int WindowH  = 3;
   localparam int MaxWidth = 1024;

   localparam int PixW  = 8;
   localparam int RowW  = 12;
   localparam int ColW  = 10;
   localparam int CfgWW = 11;
   localparam int CfgHW = 13;
   localparam int CsrDataW = 13;

   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   // Item handed from the front end to the median back end.
   typedef struct packed {
      logic [RowW-1:0] row;
      logic [ColW-1:0] col;
      logic            last;
   } tag_type;

endpackage

### hw/rtl/window_median_filter_top.sv
// Streaming 3x3 (WINDOW_W x WINDOW_H) median filter for 8-bit raster pixels.
// One pixel is taken each cycle while the window stage can advance; one result
// follows per interior pixel, from the odd-even sorting pipeline. Border
// pixels give no result and frame_last marks the last interior pixel. Line
// stores are block RAMs, one per kept row, each with one write and one
// registered read per cycle. Width and height are to be written through the
// csr port only while the block is idle; the block itself does not enforce it.
module window_median_filter_top #(
   parameter int WindowW  = wmf_pkg::WindowW,
   parameter int WindowH  = wmf_pkg::WindowH,
   parameter int MaxWidth = wmf_pkg::MaxWidth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // median_value[7:0], out_row[19:8], out_col[29:20]
   output logic        rsp_tlast    // frame_last
);

   localparam int WinBits = wmf_pkg::PixW * WindowW * WindowH;

   logic [wmf_pkg::CfgWW-1:0] width_ff;
   logic [wmf_pkg::CfgHW-1:0] height_ff;
   logic                      win_valid, win_ready;
   logic [WinBits-1:0]        win_data;
   wmf_pkg::tag_type          win_tag, out_tag;
   logic [7:0]                med;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 13'd480;
      end else if (csr_we) begin
         case (csr_index)
            wmf_pkg::CSR_IDX_WIDTH:  width_ff  <= csr_wdata[10:0];
            wmf_pkg::CSR_IDX_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   wmf_front #(.WindowW(WindowW), .WindowH(WindowH), .MaxWidth(MaxWidth)) u_front (
      .clock       (clock),
      .reset       (reset),
      .image_width (width_ff),
      .image_height(height_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_pixel    (req_tdata),
      .win_valid   (win_valid),
      .win_ready   (win_ready),
      .win_data    (win_data),
      .win_tag     (win_tag)
   );

   wmf_median #(.WindowW(WindowW), .WindowH(WindowH)) u_median (
      .clock     (clock),
      .reset     (reset),
      .win_valid (win_valid),
      .win_ready (win_ready),
      .win_data  (win_data),
      .win_tag   (win_tag),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_median(med),
      .out_tag   (out_tag)
   );

   assign rsp_tdata = {2'b00, out_tag.col, out_tag.row, med};
   assign rsp_tlast = out_tag.last;

endmodule

### hw/rtl/wmf_ram.sv
module wmf_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/wmf_front.sv
// Front end: counts raster position, reads and updates the line stores, builds
// the window and decides whether the window belongs to an interior pixel.
// Stage 0 accepts and issues the line store read; stage 1 shifts the window.
module wmf_front #(
   parameter int WindowW  = wmf_pkg::WindowW,
   parameter int WindowH  = wmf_pkg::WindowH,
   parameter int MaxWidth = wmf_pkg::MaxWidth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [wmf_pkg::CfgWW-1:0]     image_width,
   input  logic [wmf_pkg::CfgHW-1:0]     image_height,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [wmf_pkg::PixW-1:0]      in_pixel,
   output logic                          win_valid,
   input  logic                          win_ready,
   output logic [wmf_pkg::PixW*WindowW*WindowH-1:0] win_data,
   output wmf_pkg::tag_type              win_tag
);

   localparam int RowsKept = WindowH - 1;
   localparam int AddrW    = $clog2(MaxWidth);
   localparam int WinN     = WindowW * WindowH;
   localparam int PW       = wmf_pkg::PixW;
   localparam int RW       = wmf_pkg::RowW;
   localparam int CW       = wmf_pkg::ColW;
   localparam int CapW     = (MaxWidth < 1024) ? MaxWidth : 1024;

   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CW:0]     eff_w;
   logic [RW:0]     eff_h;
   logic            accept;

   // stage 1 registers
   logic            s1_valid_ff;
   logic [PW-1:0]   s1_pix_ff;
   logic            s1_inrange_ff;
   logic            s1_emit_ff;
   wmf_pkg::tag_type s1_tag_ff;
   logic [AddrW-1:0] s1_addr_ff;

   // output window
   logic [PW-1:0]   win_ff [WinN];
   logic            out_valid_ff;
   wmf_pkg::tag_type out_tag_ff;
   logic [PW-1:0]   col_pix [WindowH];
   logic [PW-1:0]   rd_data [RowsKept];
   logic            advance;

   always_comb begin
      if (image_width < 11'd3) begin
         eff_w = 11'd3;
      end else if ({1'b0, image_width} > 12'(CapW)) begin
         eff_w = 11'(CapW);
      end else begin
         eff_w = image_width;
      end
      if (image_height < 13'd3) begin
         eff_h = 13'd3;
      end else if (image_height > 13'd4096) begin
         eff_h = 13'd4096;
      end else begin
         eff_h = image_height;
      end
   end

   // The window stage moves when its output slot is empty or being taken.
   assign advance  = !out_valid_ff || win_ready;
   assign in_ready = advance;
   assign accept   = in_valid && in_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if ({1'b0, col_ff} >= eff_w - 11'd1) begin
            col_in = '0;
            row_in = ({1'b0, row_ff} >= eff_h - 13'd1) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (advance) begin
            s1_valid_ff  <= accept;
            out_valid_ff <= s1_valid_ff && s1_emit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= in_pixel;
         s1_inrange_ff <= 32'(col_ff) < MaxWidth;
         s1_addr_ff    <= AddrW'(col_ff);
         s1_emit_ff    <= row_ff >= RW'(WindowH - 1) && col_ff >= CW'(WindowW - 1)
                          && {1'b0, row_ff} < eff_h && {1'b0, col_ff} < eff_w;
         s1_tag_ff.row  <= row_ff - RW'(WindowH / 2);
         s1_tag_ff.col  <= col_ff - CW'(WindowW / 2);
         s1_tag_ff.last <= {1'b0, row_ff} == eff_h - 13'd1
                           && {1'b0, col_ff} == eff_w - 11'd1;
      end
   end

   // Line store k holds the row k+1 above the current one.
   for (genvar k = 0; k < RowsKept; k++) begin : g_line
      logic [PW-1:0] wdata;
      if (k == 0) begin : g_first
         assign wdata = s1_pix_ff;
      end else begin : g_next
         assign wdata = rd_data[k-1];
      end
      wmf_ram #(.Width(PW), .Depth(MaxWidth)) u_ram (
         .clock  (clock),
         .wr_en  (s1_valid_ff && advance && s1_inrange_ff),
         .wr_addr(s1_addr_ff),
         .wr_data(wdata),
         .rd_en  (accept),
         .rd_addr(AddrW'(col_ff)),
         .rd_data(rd_data[k])
      );
   end

   // Column oldest row first; beyond the store the upper rows read zero.
   always_comb begin
      for (int k = 0; k < RowsKept; k++) begin
         col_pix[k] = s1_inrange_ff ? rd_data[RowsKept-1-k] : '0;
      end
      col_pix[WindowH-1] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         for (int i = 0; i < WindowW - 1; i++) begin
            for (int j = 0; j < WindowH; j++) begin
               win_ff[i*WindowH+j] <= win_ff[(i+1)*WindowH+j];
            end
         end
         for (int j = 0; j < WindowH; j++) begin
            win_ff[(WindowW-1)*WindowH+j] <= col_pix[j];
         end
         out_tag_ff <= s1_tag_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < WinN; i++) begin
         win_data[i*PW +: PW] = win_ff[i];
      end
   end

   assign win_valid = out_valid_ff;
   assign win_tag   = out_tag_ff;

endmodule

### hw/rtl/wmf_median.sv
`include "window_median_filter_top_macros.svh"
// Back end: a queue of complete windows feeding a pipelined sorting network.
// Each stage does one odd or even compare-exchange pass; WinN passes sort.
module wmf_median #(
   parameter int WindowW = wmf_pkg::WindowW,
   parameter int WindowH = wmf_pkg::WindowH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          win_valid,
   output logic                          win_ready,
   input  logic [wmf_pkg::PixW*WindowW*WindowH-1:0] win_data,
   input  wmf_pkg::tag_type              win_tag,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [wmf_pkg::PixW-1:0]      out_median,
   output wmf_pkg::tag_type              out_tag
);

   localparam int WinN = WindowW * WindowH;
   localparam int PW   = wmf_pkg::PixW;
   localparam int QD   = 2;

   // two-entry queue parts the front end from the sorter
   logic [PW*WinN-1:0] q_data_ff [QD];
   wmf_pkg::tag_type   q_tag_ff [QD];
   logic               q_wp_ff, q_rp_ff;
   logic [1:0]         q_cnt_ff;
   logic               q_push, q_pop, q_nonempty;

   logic [PW-1:0]      st_ff [WinN+1][WinN];
   logic [PW-1:0]      pass_out [WinN][WinN];
   wmf_pkg::tag_type   st_tag_ff [WinN+1];
   logic               st_v_ff [WinN+1];
   logic               stall;

   assign stall      = st_v_ff[WinN] && !out_ready;
   assign q_nonempty = q_cnt_ff != 2'd0;
   assign win_ready  = q_cnt_ff != 2'(QD);
   assign q_push     = win_valid && win_ready;
   assign q_pop      = q_nonempty && !stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff  <= 1'b0;
         q_rp_ff  <= 1'b0;
         q_cnt_ff <= '0;
      end else begin
         if (q_push) begin
            q_wp_ff <= !q_wp_ff;
         end
         if (q_pop) begin
            q_rp_ff <= !q_rp_ff;
         end
         q_cnt_ff <= q_cnt_ff + 2'(q_push) - 2'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_data_ff[q_wp_ff] <= win_data;
         q_tag_ff[q_wp_ff]  <= win_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= WinN; s++) begin
            st_v_ff[s] <= 1'b0;
         end
      end else if (!stall) begin
         st_v_ff[0] <= q_pop;
         for (int s = 1; s <= WinN; s++) begin
            st_v_ff[s] <= st_v_ff[s-1];
         end
      end
   end

   // Pass s compares pairs starting at s%2 of the stage before it.
   always_comb begin
      for (int s = 0; s < WinN; s++) begin
         for (int i = 0; i < WinN; i++) begin
            pass_out[s][i] = st_ff[s][i];
         end
         for (int i = s % 2; i + 1 < WinN; i += 2) begin
            if (st_ff[s][i] > st_ff[s][i+1]) begin
               pass_out[s][i]   = st_ff[s][i+1];
               pass_out[s][i+1] = st_ff[s][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         for (int i = 0; i < WinN; i++) begin
            st_ff[0][i] <= q_data_ff[q_rp_ff][i*PW +: PW];
         end
         st_tag_ff[0] <= q_tag_ff[q_rp_ff];
         for (int s = 1; s <= WinN; s++) begin
            st_tag_ff[s] <= st_tag_ff[s-1];
            for (int i = 0; i < WinN; i++) begin
               st_ff[s][i] <= pass_out[s-1][i];
            end
         end
      end
   end

   assign out_valid  = st_v_ff[WinN];
   assign out_median = st_ff[WinN][WinN/2];
   assign out_tag    = st_tag_ff[WinN];

   `WMF_ASSERT_IMPL(a_q_bound, clock, reset, 1'b1, q_cnt_ff <= 2'(QD), "queue overfilled")
   `WMF_ASSERT_NEXT(a_hold, clock, reset, stall, out_valid && $stable(out_median), "result lost")
   `WMF_ASSERT_IMPL(a_no_pop_empty, clock, reset, q_pop, q_cnt_ff != 2'd0, "pop of empty queue")

endmodule
